[src/bfr_pkg.sv]
package bfr_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_RESET   = 32;
    localparam int FIELD_W     = 16;
    localparam int QUEUE_DEPTH = 4;

    // floor(x / d) == (x * ceil(2^SHIFT / d)) >> SHIFT for x below 2^20
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [RECIP_W-1:0] RECIP_DIV1 = RECIP_W'(16777216);
    localparam logic [RECIP_W-1:0] RECIP_DIV2 = RECIP_W'(8388608);
    localparam logic [RECIP_W-1:0] RECIP_DIV3 = RECIP_W'(5592406);
    localparam logic [RECIP_W-1:0] RECIP_DIV4 = RECIP_W'(4194304);
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = RECIP_W'(2796203);
    localparam logic [RECIP_W-1:0] RECIP_DIV9 = RECIP_W'(1864136);

    typedef struct packed {
        logic out_en;
        logic row_lo;
        logic row_hi;
        logic col_lo;
        logic col_hi;
        logic frame_end;
    } t_ctl;

    typedef enum logic [1:0] {
        SPAN_ONE,
        SPAN_TWO,
        SPAN_THREE
    } t_span;

    function automatic t_span span_of(input logic lo, input logic hi);
        t_span s;
        if (lo && hi) begin
            s = SPAN_THREE;
        end else if (lo || hi) begin
            s = SPAN_TWO;
        end else begin
            s = SPAN_ONE;
        end
        return s;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input t_span rows, input t_span cols);
        logic [RECIP_W-1:0] m;
        m = RECIP_DIV1;
        case (rows)
            SPAN_ONE: begin
                case (cols)
                    SPAN_ONE:   m = RECIP_DIV1;
                    SPAN_TWO:   m = RECIP_DIV2;
                    SPAN_THREE: m = RECIP_DIV3;
                    default:    m = RECIP_DIV1;
                endcase
            end
            SPAN_TWO: begin
                case (cols)
                    SPAN_ONE:   m = RECIP_DIV2;
                    SPAN_TWO:   m = RECIP_DIV4;
                    SPAN_THREE: m = RECIP_DIV6;
                    default:    m = RECIP_DIV1;
                endcase
            end
            SPAN_THREE: begin
                case (cols)
                    SPAN_ONE:   m = RECIP_DIV3;
                    SPAN_TWO:   m = RECIP_DIV6;
                    SPAN_THREE: m = RECIP_DIV9;
                    default:    m = RECIP_DIV1;
                endcase
            end
            default: m = RECIP_DIV1;
        endcase
        return m;
    endfunction

endpackage

[src/bfr_if.sv]
interface bfr_in_if import bfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] in_red;
    logic [FIELD_W-1:0] in_green;
    logic [FIELD_W-1:0] in_blue;
    logic               drain;

    modport source (output valid, in_red, in_green, in_blue, drain, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, drain, output ready);
endinterface

interface bfr_out_if import bfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] out_red;
    logic [FIELD_W-1:0] out_green;
    logic [FIELD_W-1:0] out_blue;
    logic               frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[src/bfr_front.sv]
module bfr_front import bfr_pkg::*; #(
    parameter int MAX_SIZE     = 1024,
    parameter int CHANNEL_BITS = 16,
    parameter int ADDR_W       = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data,
    bfr_in_if.sink                    i_pix,
    input  logic                      i_full,
    output logic                      o_push,
    output logic [ADDR_W-1:0]         o_addr,
    output logic [3*CHANNEL_BITS-1:0] o_pix,
    output t_ctl                      o_ctl
);

    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
    localparam int CMP_W    = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int WARM_W   = $clog2(MAX_SIZE + 2);
    localparam int RESET_M1 = ((CFG_RESET > MAX_SIZE) ? MAX_SIZE : CFG_RESET) - 1;

    logic [ADDR_W-1:0] r_size_m1, n_size_m1;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [ADDR_W-1:0] r_row, n_row;
    logic              r_drain_ph, n_drain_ph;
    logic [WARM_W-1:0] r_warm, n_warm;
    logic [ADDR_W-1:0] r_p_col, n_p_col;
    logic [ADDR_W-1:0] r_p_row, n_p_row;

    logic              pix_phase;
    logic              take;
    logic              out_en;
    logic              frame_end;
    logic              col_wrap;
    logic [CMP_W-1:0]  cfg_ext;

    assign pix_phase   = !r_drain_ph;
    assign i_pix.ready = !i_full;
    assign take        = i_pix.valid && i_pix.ready;
    assign o_push      = take && !(pix_phase && i_pix.drain);

    assign out_en    = (r_warm == (WARM_W'(r_size_m1) + WARM_W'(2)));
    assign frame_end = out_en && (r_p_row == r_size_m1) && (r_p_col == r_size_m1);
    assign col_wrap  = (r_col == r_size_m1);
    assign cfg_ext   = CMP_W'(i_cfg_data);

    assign o_addr = r_col;
    assign o_pix  = pix_phase ? {i_pix.in_red[CHANNEL_BITS-1:0],
                                 i_pix.in_green[CHANNEL_BITS-1:0],
                                 i_pix.in_blue[CHANNEL_BITS-1:0]} : '0;

    always_comb begin
        o_ctl.out_en    = out_en;
        o_ctl.row_lo    = (r_p_row != '0);
        o_ctl.row_hi    = (r_p_row != r_size_m1);
        o_ctl.col_lo    = (r_p_col != '0);
        o_ctl.col_hi    = (r_p_col != r_size_m1);
        o_ctl.frame_end = frame_end;
    end

    always_comb begin
        n_size_m1  = r_size_m1;
        n_col      = r_col;
        n_row      = r_row;
        n_drain_ph = r_drain_ph;
        n_warm     = r_warm;
        n_p_col    = r_p_col;
        n_p_row    = r_p_row;
        if (i_cfg_we) begin
            if (cfg_ext == '0) begin
                n_size_m1 = '0;
            end else if (cfg_ext > CMP_W'(MAX_SIZE)) begin
                n_size_m1 = ADDR_W'(MAX_SIZE - 1);
            end else begin
                n_size_m1 = ADDR_W'(cfg_ext - CMP_W'(1));
            end
            n_col      = '0;
            n_row      = '0;
            n_drain_ph = 1'b0;
            n_warm     = '0;
            n_p_col    = '0;
            n_p_row    = '0;
        end else if (o_push) begin
            if (frame_end) begin
                n_col      = '0;
                n_row      = '0;
                n_drain_ph = 1'b0;
                n_warm     = '0;
                n_p_col    = '0;
                n_p_row    = '0;
            end else begin
                n_col = col_wrap ? '0 : r_col + ADDR_W'(1);
                if (pix_phase && col_wrap) begin
                    n_row = r_row + ADDR_W'(1);
                    if (r_row == r_size_m1) begin
                        n_drain_ph = 1'b1;
                    end
                end
                if (out_en) begin
                    if (r_p_col == r_size_m1) begin
                        n_p_col = '0;
                        n_p_row = r_p_row + ADDR_W'(1);
                    end else begin
                        n_p_col = r_p_col + ADDR_W'(1);
                    end
                end else begin
                    n_warm = r_warm + WARM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_m1  <= ADDR_W'(RESET_M1);
            r_col      <= '0;
            r_row      <= '0;
            r_drain_ph <= 1'b0;
            r_warm     <= '0;
            r_p_col    <= '0;
            r_p_row    <= '0;
        end else begin
            r_size_m1  <= n_size_m1;
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain_ph <= n_drain_ph;
            r_warm     <= n_warm;
            r_p_col    <= n_p_col;
            r_p_row    <= n_p_row;
        end
    end

endmodule

[src/bfr_fifo.sv]
module bfr_fifo import bfr_pkg::*; #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/bfr_back.sv]
module bfr_back import bfr_pkg::*; #(
    parameter int MAX_SIZE     = 1024,
    parameter int CHANNEL_BITS = 16,
    parameter int ADDR_W       = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  logic [ADDR_W-1:0]         i_q_addr,
    input  logic [3*CHANNEL_BITS-1:0] i_q_pix,
    input  t_ctl                      i_q_ctl,
    output logic                      o_pop,
    bfr_out_if.source                 o_res
);

    localparam int PIX_W  = 3 * CHANNEL_BITS;
    localparam int SUM_W  = CHANNEL_BITS + 4;
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [2*PIX_W-1:0]  r_line_mem [MAX_SIZE];
    logic [PIX_W-1:0]    r_win [3][3];

    logic                r_b_valid;
    logic [ADDR_W-1:0]   r_b_addr;
    logic [PIX_W-1:0]    r_b_pix;
    t_ctl                r_b_ctl;
    logic [2*PIX_W-1:0]  r_rd;

    logic                r_c_valid;
    t_ctl                r_c_ctl;

    logic                r_d_valid;
    logic [SUM_W-1:0]    r_d_sum [3];
    logic [RECIP_W-1:0]  r_d_recip;
    logic                r_d_fe;

    logic                    r_out_valid;
    logic [CHANNEL_BITS-1:0] r_out_chan [3];
    logic                    r_out_fe;

    logic                adv;
    logic                fwd;
    logic [2*PIX_W-1:0]  wr_data;
    logic [PIX_W-1:0]    col_in [3];
    logic [2:0]          row_ok;
    logic [2:0]          col_ok;
    logic [SUM_W-1:0]    row_sum [3][3];
    logic [SUM_W-1:0]    sum [3];
    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod [3];

    assign adv   = !r_out_valid || o_res.ready;
    assign o_pop = adv;

    // older row takes the previous newer entry, newer row takes this pixel
    assign wr_data   = {r_rd[PIX_W-1:0], r_b_pix};
    assign fwd       = r_b_valid && (r_b_addr == i_q_addr);
    assign col_in[0] = r_rd[2*PIX_W-1:PIX_W];
    assign col_in[1] = r_rd[PIX_W-1:0];
    assign col_in[2] = r_b_pix;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_b_valid) begin
                r_line_mem[r_b_addr] <= wr_data;
            end
            if (fwd) begin
                r_rd <= wr_data;
            end else begin
                r_rd <= r_line_mem[i_q_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
                r_win[i][2] <= col_in[i];
            end
        end
    end

    assign row_ok = {r_c_ctl.row_hi, 1'b1, r_c_ctl.row_lo};
    assign col_ok = {r_c_ctl.col_hi, 1'b1, r_c_ctl.col_lo};

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                row_sum[i][ch] = '0;
                for (int j = 0; j < 3; j++) begin
                    if (row_ok[i] && col_ok[j]) begin
                        row_sum[i][ch] = row_sum[i][ch]
                            + SUM_W'(r_win[i][j][(2-ch)*CHANNEL_BITS +: CHANNEL_BITS]);
                    end
                end
            end
            sum[ch] = row_sum[0][ch] + row_sum[1][ch] + row_sum[2][ch];
        end
    end

    assign recip = recip_of(span_of(r_c_ctl.row_lo, r_c_ctl.row_hi),
                            span_of(r_c_ctl.col_lo, r_c_ctl.col_hi));

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(r_d_sum[ch]) * PROD_W'(r_d_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid   <= i_q_valid;
            r_c_valid   <= r_b_valid && r_b_ctl.out_en;
            r_d_valid   <= r_c_valid;
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_addr  <= i_q_addr;
            r_b_pix   <= i_q_pix;
            r_b_ctl   <= i_q_ctl;
            r_c_ctl   <= r_b_ctl;
            r_d_sum   <= sum;
            r_d_recip <= recip;
            r_d_fe    <= r_c_ctl.frame_end;
            for (int ch = 0; ch < 3; ch++) begin
                r_out_chan[ch] <= prod[ch][RECIP_SHIFT +: CHANNEL_BITS];
            end
            r_out_fe <= r_d_fe;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = FIELD_W'(r_out_chan[0]);
    assign o_res.out_green = FIELD_W'(r_out_chan[1]);
    assign o_res.out_blue  = FIELD_W'(r_out_chan[2]);
    assign o_res.frame_end = r_out_fe;

endmodule

[src/box_filter_3x3_rgb.sv]
// 3x3 box blur over a square RGB image streamed in raster order. Pixels are taken
// at one word per clock while the queue has room; a four-word queue sits between
// the input side and the filter pipeline, so input keeps flowing for a few words
// while the result port stalls. The word that completes a result passes the queue,
// the read, window and sum registers and then the output register, and the first
// result of a frame follows the word that comes image_size+1 words into it; send
// image_size+1 drain words after the last pixel to flush the tail. Drain words
// during the pixels are dropped. The pair of line stores is one dual-row memory of
// MAX_SIZE entries, read and written once per word; it needs no clearing after
// reset. Write image_size only while idle: the write also restarts the frame.
module box_filter_3x3_rgb import bfr_pkg::*; #(
    parameter int MAX_SIZE     = 1024,
    parameter int CHANNEL_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    bfr_in_if.sink           i_pix,
    bfr_out_if.source        o_res
);

    localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int PIX_W  = 3 * CHANNEL_BITS;
    localparam int CTL_W  = $bits(t_ctl);
    localparam int Q_W    = ADDR_W + PIX_W + CTL_W;

    logic              w_push;
    logic              w_full;
    logic [ADDR_W-1:0] w_addr;
    logic [PIX_W-1:0]  w_pix;
    t_ctl              w_ctl;
    logic              w_pop;
    logic              w_q_valid;
    logic [Q_W-1:0]    w_q_data;
    logic [ADDR_W-1:0] w_q_addr;
    logic [PIX_W-1:0]  w_q_pix;
    t_ctl              w_q_ctl;

    bfr_front #(
        .MAX_SIZE     (MAX_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_addr     (w_addr),
        .o_pix      (w_pix),
        .o_ctl      (w_ctl)
    );

    bfr_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_addr, w_pix, w_ctl}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_addr = w_q_data[Q_W-1 -: ADDR_W];
    assign w_q_pix  = w_q_data[CTL_W +: PIX_W];
    assign w_q_ctl  = t_ctl'(w_q_data[CTL_W-1:0]);

    bfr_back #(
        .MAX_SIZE     (MAX_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_addr  (w_q_addr),
        .i_q_pix   (w_q_pix),
        .i_q_ctl   (w_q_ctl),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result word valid straight after reset");

    a_frame_end_is_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_ctl.frame_end) |-> w_ctl.out_en)
        else $error("frame end marked on a word that yields no result");

    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready && w_q_valid) |=> w_q_valid)
        else $error("queue head lost while the result port stalls");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bfr_pkg::*;

    localparam int ROW_MAX         = 1024;
    localparam int SETTLE_CYCLES   = 32;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
        logic               drain;
    } t_word;

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
        logic               frame_end;
    } t_mean;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    bfr_in_if  pix ();
    bfr_out_if res ();

    box_filter_3x3_rgb uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    // filter state as seen by the predictor
    logic [CFG_W-1:0]     size_cfg;
    logic [3*FIELD_W-1:0] row_far  [ROW_MAX];
    logic [3*FIELD_W-1:0] row_near [ROW_MAX];
    logic [3*FIELD_W-1:0] nbhd     [9];
    logic [20:0]          word_pos;

    t_mean       pending_means [$];
    int          mismatch_count;
    int          cycle_count;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          force_ready;
    int          hold_off_asks;
    int          hold_off_served;
    int          hold_off_left;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("box_filter_3x3_rgb: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                               input logic [FIELD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
        end
    endtask

    task automatic predict_means(input t_word w);
        int n, total, k, cin, p, row, col, cnt, i, j, rr, cc;
        int unsigned sr, sg, sb;
        logic [3*FIELD_W-1:0] px, wv;
        logic [3*FIELD_W-1:0] column [3];
        t_mean m;
        n = (size_cfg == 0) ? 1 : ((int'(size_cfg) > ROW_MAX) ? ROW_MAX : int'(size_cfg));
        total = n * n;
        k = int'(word_pos);
        px = '0;
        if (k < total) begin
            if (w.drain) begin
                return;
            end
            px = {w.red, w.green, w.blue};
        end
        cin = k % n;
        column[0] = row_far[cin];
        column[1] = row_near[cin];
        column[2] = px;
        row_far[cin] = column[1];
        row_near[cin] = px;
        for (i = 0; i < 3; i++) begin
            nbhd[i*3]   = nbhd[i*3+1];
            nbhd[i*3+1] = nbhd[i*3+2];
            nbhd[i*3+2] = column[i];
        end
        word_pos = (k >= total + n) ? '0 : 21'(k + 1);
        if (k < n + 1) begin
            return;
        end
        p = k - n - 1;
        row = p / n;
        col = p % n;
        sr = 0;
        sg = 0;
        sb = 0;
        cnt = 0;
        for (i = 0; i < 3; i++) begin
            rr = row - 1 + i;
            if (rr < 0 || rr >= n) continue;
            for (j = 0; j < 3; j++) begin
                cc = col - 1 + j;
                if (cc < 0 || cc >= n) continue;
                wv = nbhd[i*3+j];
                sr += wv[47:32];
                sg += wv[31:16];
                sb += wv[15:0];
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        m.red       = FIELD_W'(sr / cnt);
        m.green     = FIELD_W'(sg / cnt);
        m.blue      = FIELD_W'(sb / cnt);
        m.frame_end = (p == total - 1);
        pending_means.push_back(m);
    endtask

    always @(posedge i_clk) begin : result_check
        t_mean want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h %h %h end=%b",
                    res.out_red, res.out_green, res.out_blue, res.frame_end));
            end else begin
                want = pending_means.pop_front();
                check_field("red", res.out_red, want.red);
                check_field("green", res.out_green, want.green);
                check_field("blue", res.out_blue, want.blue);
                check_field("frame_end", FIELD_W'(res.frame_end), FIELD_W'(want.frame_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off_served != hold_off_asks) begin
            hold_off_served = hold_off_asks;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            res.ready <= 1'b0;
        end else if (force_ready) begin
            res.ready <= 1'b1;
        end else begin
            res.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [FIELD_W-1:0] rand_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic t_word make_word(input logic [FIELD_W-1:0] r, input logic [FIELD_W-1:0] g,
                                        input logic [FIELD_W-1:0] b, input logic d);
        t_word w;
        w.red   = r;
        w.green = g;
        w.blue  = b;
        w.drain = d;
        return w;
    endfunction

    function automatic t_word rand_word(input logic d);
        return make_word(rand_channel(), rand_channel(), rand_channel(), d);
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 12) return CFG_W'(1);
        if (r < 75) return CFG_W'($urandom_range(6, 2));
        return CFG_W'($urandom_range(12, 7));
    endfunction

    task automatic send_word(input t_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.in_red   <= w.red;
        pix.in_green <= w.green;
        pix.in_blue  <= w.blue;
        pix.drain    <= w.drain;
        do begin
            @(posedge i_clk);
        end while (!pix.ready);
        predict_means(w);
    endtask

    task automatic wait_quiet();
        pix.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_means.size() != 0);
        force_ready <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        force_ready <= 1'b0;
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_cfg = v;
        word_pos = '0;
    endtask

    task automatic set_idling(input int unsigned src, input int unsigned sink);
        src_idle_pct = src;
        sink_idle_pct <= sink;
    endtask

    // partial frame at the size out of reset, cut short by the next write
    task automatic test_reset_size();
        int idx;
        for (idx = 0; idx < 40; idx++) begin
            send_word(rand_word(1'b0));
        end
        wait_quiet();
    endtask

    task automatic test_tiny_sizes();
        int s, n, idx;
        logic [FIELD_W-1:0] v;
        for (s = 0; s < 4; s++) begin
            write_size(CFG_W'(s));
            n = (s == 0) ? 1 : s;
            if (s[0]) begin
                send_word(make_word('1, '1, '1, 1'b1));
            end
            for (idx = 0; idx < n * n; idx++) begin
                v = idx[0] ? '1 : '0;
                send_word(make_word(v, ~v, (idx == n * n - 1) ? 16'h8001 : v, 1'b0));
            end
            for (idx = 0; idx <= n; idx++) begin
                send_word(make_word('1, '1, '1, idx[0]));
            end
        end
        wait_quiet();
    endtask

    // an oversized register value must act as the largest line
    task automatic test_size_clamp();
        int s, idx;
        for (s = 0; s < 3; s++) begin
            write_size((s == 2) ? '1 : CFG_W'(ROW_MAX + 1 + 2 * s));
            for (idx = 0; idx < 12; idx++) begin
                send_word(rand_word(1'b0));
            end
        end
        wait_quiet();
    endtask

    task automatic test_backpressure();
        int idx, n;
        n = 6;
        write_size(CFG_W'(n));
        hold_off_asks <= hold_off_asks + 1;
        for (idx = 0; idx < n * n + n + 1; idx++) begin
            send_word(rand_word(idx >= n * n));
            if (idx == 30) begin
                pix.valid <= 1'b0;
                do begin
                    @(posedge i_clk);
                end while (pending_means.size() != 0);
            end
        end
        wait_quiet();
    endtask

    task automatic test_random_frames(input int budget);
        int sent, n, last, cut, idx;
        bit fresh;
        sent = 0;
        fresh = 1'b1;
        while (sent < budget) begin
            if (fresh || $urandom_range(1) == 0) begin
                write_size(pick_size());
            end
            n = (size_cfg == 0) ? 1 : int'(size_cfg);
            last = n * n + n + 1;
            cut = ($urandom_range(99) < 15) ? int'($urandom_range(last - 1)) : last;
            for (idx = 0; idx < cut; idx++) begin
                if (idx < n * n) begin
                    if ($urandom_range(99) < 8) begin
                        send_word(rand_word(1'b1));
                    end
                    send_word(rand_word(1'b0));
                end else begin
                    send_word(rand_word($urandom_range(99) < 80));
                end
                sent++;
            end
            fresh = (cut != last);
        end
        wait_quiet();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        pix.valid    = 1'b0;
        pix.in_red   = '0;
        pix.in_green = '0;
        pix.in_blue  = '0;
        pix.drain    = 1'b0;
        res.ready    = 1'b0;
        size_cfg     = CFG_W'(CFG_RESET);
        word_pos     = '0;
        foreach (row_far[i]) row_far[i] = '0;
        foreach (row_near[i]) row_near[i] = '0;
        foreach (nbhd[i]) nbhd[i] = '0;
        set_idling(20, 61);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_size();
        test_tiny_sizes();
        test_size_clamp();
        test_random_frames(120);
        set_idling(61, 20);
        test_random_frames(120);
        set_idling(0, 0);
        test_backpressure();
        test_random_frames(120);

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("box_filter_3x3_rgb: match");
        end else begin
            $display("box_filter_3x3_rgb: mismatch");
        end
        $finish;
    end

endmodule
